// ===== src/doig_pkg.sv =====
// ----------------------------------------------------------------------------
// doig_pkg: shared types and constants for the orientation index generator
// Shape codes, status codes, field widths and the triangular row offset table.
// ----------------------------------------------------------------------------
`default_nettype none

package doig_pkg;

    localparam int SHAPE_W  = 2;
    localparam int CORNER_W = 2;
    localparam int ORDER_W  = 4;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int GRID_W   = 3;   // inner grid coordinate, q is at most 7

    localparam int DEF_MAX_ORDER = 9;

    typedef logic [SHAPE_W-1:0]  t_shape;
    typedef logic [CORNER_W-1:0] t_corner;
    typedef logic [ORDER_W-1:0]  t_order;
    typedef logic [INDEX_W-1:0]  t_index;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [GRID_W-1:0]   t_grid;

    localparam t_shape SHAPE_EDGE = 2'd0;
    localparam t_shape SHAPE_TRI  = 2'd1;
    localparam t_shape SHAPE_QUAD = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_NONE = 2'd1;
    localparam t_status ST_ERR  = 2'd2;

    // j*(j-1)/2: points dropped from the rows below row j of a triangle
    function automatic t_index tri_drop(input t_grid j);
        t_index v;
        case (j)
            3'd0:    v = 6'd0;
            3'd1:    v = 6'd0;
            3'd2:    v = 6'd1;
            3'd3:    v = 6'd3;
            3'd4:    v = 6'd6;
            3'd5:    v = 6'd10;
            3'd6:    v = 6'd15;
            default: v = 6'd21;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/dof_orientation_index_generator_unit.sv =====
// ----------------------------------------------------------------------------
// dof_orientation_index_generator_unit: interior DoF orientation permutation
// Walks the inner point grid of an edge, triangle or quad and emits one
// natural index per output transfer.
// ----------------------------------------------------------------------------
// One request is taken when the unit is idle; it then produces its results one
// per cycle, unless the output side stalls, through a single multiply-add index
// unit (j*(q+1) + i, less the triangular offset), driven by a column/row counter
// pair. A request yields p-1 results for an edge, (q+1)(q+2)/2 with q = p-3 for
// a triangle, (q+1)^2 with q = p-2 for a quad (64 results for a quad of order
// 9), or one result for a low order, a bad corner or a bad shape. The input
// side is ready again once the last result is loaded into the output register.
// Orders above MAX_ORDER are clamped to MAX_ORDER.
`default_nettype none

module dof_orientation_index_generator_unit #(
    parameter int MAX_ORDER = doig_pkg::DEF_MAX_ORDER
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire doig_pkg::t_shape  i_shape,
    input  wire doig_pkg::t_corner i_first_corner,
    input  wire doig_pkg::t_corner i_second_corner,
    input  wire doig_pkg::t_order  i_order,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output doig_pkg::t_index      o_natural_index,
    output logic                  o_last,
    output doig_pkg::t_status     o_status
);
    import doig_pkg::*;

    localparam t_order MaxOrd = t_order'(MAX_ORDER);

    logic    r_busy;
    t_shape  r_shape;
    t_corner r_c0;
    logic    r_same;
    t_grid   r_q;
    t_status r_mode;
    t_grid   r_mi;
    t_grid   r_mj;

    logic    r_out_valid;
    t_index  r_idx;
    logic    r_last;
    t_status r_status;

    logic    w_accept;
    logic    w_load;
    t_order  w_p;
    t_status w_mode;
    t_order  w_q4;
    logic    w_same;

    t_grid   w_qmi;
    t_grid   w_tri_rem;
    t_grid   w_ri;
    t_grid   w_rj;
    t_grid   w_i;
    t_grid   w_j;
    logic [6:0] w_prod;
    t_index  w_idx;
    logic    w_row_end;
    logic    w_is_last;

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = r_busy && (!r_out_valid || i_out_ready);

    // decode a new request
    always_comb begin
        w_p    = (i_order > MaxOrd) ? MaxOrd : i_order;
        w_mode = ST_OK;
        w_q4   = w_p - 4'd2;
        w_same = 1'b0;
        if (w_p <= 4'd2) begin
            w_mode = ST_NONE;
        end else begin
            case (i_shape)
                SHAPE_EDGE: begin
                    if (i_first_corner > 2'd1) w_mode = ST_ERR;
                end
                SHAPE_TRI: begin
                    w_q4 = w_p - 4'd3;
                    if (i_first_corner > 2'd2) w_mode = ST_ERR;
                    w_same = (i_first_corner == 2'd2) ? (i_second_corner == 2'd0)
                                                      : (i_second_corner ==
                                                         i_first_corner + 2'd1);
                end
                SHAPE_QUAD: begin
                    w_same = (i_second_corner == i_first_corner + 2'd1);
                end
                default: w_mode = ST_ERR;
            endcase
        end
    end

    // rotate, mirror and linearize the current grid point
    always_comb begin
        w_qmi     = r_q - r_mi;
        w_tri_rem = r_q - r_mi - r_mj;
        w_ri      = r_mi;
        w_rj      = r_mj;
        if (r_shape == SHAPE_TRI) begin
            case (r_c0)
                2'd0:    begin w_ri = r_mi;      w_rj = r_mj;      end
                2'd1:    begin w_ri = r_mj;      w_rj = w_tri_rem; end
                default: begin w_ri = w_tri_rem; w_rj = r_mi;      end
            endcase
        end else begin
            case (r_c0)
                2'd0:    begin w_ri = r_mi;        w_rj = r_mj;        end
                2'd1:    begin w_ri = r_mj;        w_rj = w_qmi;       end
                2'd2:    begin w_ri = w_qmi;       w_rj = r_q - r_mj;  end
                default: begin w_ri = r_q - r_mj;  w_rj = r_mi;        end
            endcase
        end
        w_i = r_same ? w_ri : w_rj;
        w_j = r_same ? w_rj : w_ri;

        w_prod = 7'(w_j) * (7'(r_q) + 7'd1);
        case (r_shape)
            SHAPE_EDGE: w_idx = (r_c0 == 2'd0) ? t_index'(r_mi) : t_index'(w_qmi);
            SHAPE_TRI:  w_idx = w_prod[INDEX_W-1:0] - tri_drop(w_j) + t_index'(w_i);
            default:    w_idx = w_prod[INDEX_W-1:0] + t_index'(w_i);
        endcase

        w_row_end = (r_shape == SHAPE_TRI) ? (r_mi == r_q - r_mj) : (r_mi == r_q);
        case (r_shape)
            SHAPE_EDGE: w_is_last = (r_mi == r_q);
            SHAPE_TRI:  w_is_last = (r_mj == r_q);
            default:    w_is_last = (r_mi == r_q) && (r_mj == r_q);
        endcase
        if (r_mode != ST_OK) w_is_last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy  <= 1'b1;
                r_shape <= i_shape;
                r_c0    <= i_first_corner;
                r_same  <= w_same;
                r_q     <= w_q4[GRID_W-1:0];
                r_mode  <= w_mode;
                r_mi    <= '0;
                r_mj    <= '0;
            end else if (w_load) begin
                if (w_is_last) begin
                    r_busy <= 1'b0;
                end else if (w_row_end) begin
                    r_mi <= '0;
                    r_mj <= r_mj + 3'd1;
                end else begin
                    r_mi <= r_mi + 3'd1;
                end
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload: hold until transfer
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_idx    <= (r_mode == ST_OK) ? w_idx : '0;
            r_last   <= w_is_last;
            r_status <= r_mode;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_natural_index = r_idx;
    assign o_last          = r_last;
    assign o_status        = r_status;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("request accepted but unit not busy");

    a_special_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_last && o_natural_index == '0))
        else $error("special result must be a single zero-index last result");

    a_tri_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_mode == ST_OK && r_shape == SHAPE_TRI)
            |-> (4'(r_mi) + 4'(r_mj) <= 4'(r_q)))
        else $error("triangle walk left the inner grid");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_is_last && !w_accept) |=> !r_busy)
        else $error("unit still busy after last result");

endmodule

`default_nettype wire

// ===== test/tb_dof_orientation_index_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dof_orientation_index_generator_unit: self-checking bench
// Sends edge, triangle and quad requests over the input handshake, predicts
// the interior DoF permutation of each one, and checks every output transfer
// in order against it, under random and long output stalls.
// ----------------------------------------------------------------------------

module tb_dof_orientation_index_generator_unit;

    import doig_pkg::*;

    localparam int ORDER_CAP = DEF_MAX_ORDER;

    typedef struct packed {
        t_index  idx;
        logic    last;
        t_status status;
    } t_dof_result;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_shape   i_shape;
    t_corner  i_first_corner;
    t_corner  i_second_corner;
    t_order   i_order;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_index   o_natural_index;
    logic     o_last;
    t_status  o_status;

    t_dof_result expected_dofs[$];
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_request = 0;

    dof_orientation_index_generator_unit #(
        .MAX_ORDER(ORDER_CAP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_shape        (i_shape),
        .i_first_corner (i_first_corner),
        .i_second_corner(i_second_corner),
        .i_order        (i_order),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_natural_index(o_natural_index),
        .o_last         (o_last),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void queue_dof(input int idx, input bit last, input t_status st);
        t_dof_result r;
        r.idx    = t_index'(idx);
        r.last   = last;
        r.status = st;
        expected_dofs.insert(expected_dofs.size(), r);
    endfunction

    // Expected permutation for one request, appended in output order.
    function automatic void predict_permutation(input t_shape shape, input t_corner c0,
                                                input t_corner c1, input t_order order);
        int p, q, i, j, t, idx, mi, mj, c;
        bit same;
        p = (int'(order) > ORDER_CAP) ? ORDER_CAP : int'(order);
        if (p <= 2) begin
            queue_dof(0, 1'b1, ST_NONE);
            return;
        end
        case (shape)
            SHAPE_EDGE: begin
                if (c0 > 1) begin
                    queue_dof(0, 1'b1, ST_ERR);
                end else begin
                    for (i = 0; i < p - 1; i++)
                        queue_dof((c0 == 0) ? i : p - 2 - i, i == p - 2, ST_OK);
                end
            end
            SHAPE_TRI: begin
                if (c0 > 2) begin
                    queue_dof(0, 1'b1, ST_ERR);
                end else begin
                    same = (int'(c1) == (int'(c0) + 1) % 3);
                    q = p - 3;
                    for (mj = 0; mj <= q; mj++) begin
                        for (mi = 0; mi <= q - mj; mi++) begin
                            if (c0 == 0) begin
                                i = mi;          j = mj;
                            end else if (c0 == 1) begin
                                i = mj;          j = q - mi - mj;
                            end else begin
                                i = q - mi - mj; j = mi;
                            end
                            if (!same) begin
                                t = i; i = j; j = t;
                            end
                            // skip the full rows below row j
                            idx = i;
                            for (c = 0; c < j; c++)
                                idx += q + 1 - c;
                            queue_dof(idx, mj == q, ST_OK);
                        end
                    end
                end
            end
            SHAPE_QUAD: begin
                same = (c1 == t_corner'(c0 + 1));
                q = p - 2;
                for (mj = 0; mj <= q; mj++) begin
                    for (mi = 0; mi <= q; mi++) begin
                        case (c0)
                            2'd0:    begin i = mi;     j = mj;     end
                            2'd1:    begin i = mj;     j = q - mi; end
                            2'd2:    begin i = q - mi; j = q - mj; end
                            default: begin i = q - mj; j = mi;     end
                        endcase
                        if (!same) begin
                            t = i; i = j; j = t;
                        end
                        queue_dof((q + 1) * j + i, mj == q && mi == q, ST_OK);
                    end
                end
            end
            default: queue_dof(0, 1'b1, ST_ERR);
        endcase
    endfunction

    // Offer one request; valid stays high afterwards unless a gap follows.
    task automatic send_request(input t_shape shape, input t_corner c0,
                                input t_corner c1, input t_order order);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_shape         <= shape;
        i_first_corner  <= c0;
        i_second_corner <= c1;
        i_order         <= order;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_permutation(shape, c0, c1, order);
    endtask

    // Drop valid and hold until every expected index has been seen.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_dofs.size() != 0);
    endtask

    // Receiver: random ready, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        static int hold_left = 0;
        if (stall_request != 0) begin
            hold_left     = stall_request;
            stall_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_dof_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_dofs.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got index %0d last %0d status %0d",
                         $time, o_natural_index, o_last, o_status);
            end else begin
                want = expected_dofs.pop_front();
                if (o_natural_index !== want.idx) begin
                    mismatches++;
                    $display("%0t: natural_index expected %0d got %0d",
                             $time, want.idx, o_natural_index);
                end
                if (o_last !== want.last) begin
                    mismatches++;
                    $display("%0t: last expected %0d got %0d", $time, want.last, o_last);
                end
                if (o_status !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d got %0d", $time, want.status, o_status);
                end
            end
        end
    end

    task automatic test_low_order();
        send_request(SHAPE_EDGE, 2'd0, 2'd0, 4'd0);
        send_request(SHAPE_TRI,  2'd3, 2'd3, 4'd1);
        send_request(SHAPE_QUAD, 2'd1, 2'd2, 4'd2);
        // low order wins over a bad shape
        send_request(2'd3,       2'd3, 2'd3, 4'd2);
    endtask

    task automatic test_bad_corner();
        send_request(SHAPE_EDGE, 2'd2, 2'd0, 4'd5);
        send_request(SHAPE_EDGE, 2'd3, 2'd3, 4'd9);
        send_request(SHAPE_TRI,  2'd3, 2'd0, 4'd4);
        send_request(2'd3,       2'd0, 2'd1, 4'd9);
        send_request(2'd3,       2'd3, 2'd3, 4'd15);
    endtask

    task automatic test_edges();
        send_request(SHAPE_EDGE, 2'd0, 2'd3, 4'd3);
        send_request(SHAPE_EDGE, 2'd1, 2'd2, 4'd9);
        send_request(SHAPE_EDGE, 2'd0, 2'd1, 4'd15);
        send_request(SHAPE_EDGE, 2'd1, 2'd0, 4'd4);
    endtask

    task automatic test_faces();
        send_request(SHAPE_TRI,  2'd0, 2'd1, 4'd3);
        send_request(SHAPE_TRI,  2'd1, 2'd2, 4'd5);
        send_request(SHAPE_TRI,  2'd2, 2'd0, 4'd9);
        send_request(SHAPE_TRI,  2'd0, 2'd2, 4'd6);
        send_request(SHAPE_TRI,  2'd2, 2'd1, 4'd15);
        send_request(SHAPE_QUAD, 2'd0, 2'd1, 4'd3);
        send_request(SHAPE_QUAD, 2'd1, 2'd2, 4'd9);
        send_request(SHAPE_QUAD, 2'd2, 2'd3, 4'd5);
        // corner 3 wraps to corner 0 for the unmirrored case
        send_request(SHAPE_QUAD, 2'd3, 2'd0, 4'd6);
        send_request(SHAPE_QUAD, 2'd3, 2'd2, 4'd15);
        send_request(SHAPE_QUAD, 2'd0, 2'd0, 4'd4);
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int count);
        t_shape  shape;
        t_corner c0, c1;
        t_order  order;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            if ($urandom_range(0, 99) < 80) begin
                shape = t_shape'($urandom_range(0, 2));
                case (shape)
                    SHAPE_EDGE: c0 = t_corner'($urandom_range(0, 1));
                    SHAPE_TRI:  c0 = t_corner'($urandom_range(0, 2));
                    default:    c0 = t_corner'($urandom_range(0, 3));
                endcase
                if ($urandom_range(0, 1) == 0)
                    c1 = (shape == SHAPE_TRI) ? t_corner'((c0 + 1) % 3) : t_corner'(c0 + 1);
                else
                    c1 = t_corner'($urandom_range(0, 3));
                order = t_order'($urandom_range(3, ORDER_CAP));
            end else begin
                shape = t_shape'($urandom_range(0, 3));
                c0    = t_corner'($urandom_range(0, 3));
                c1    = t_corner'($urandom_range(0, 3));
                order = t_order'($urandom_range(0, 15));
            end
            send_request(shape, c0, c1, order);
        end
    endtask

    // Hold the output off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 300;
        send_request(SHAPE_QUAD, 2'd2, 2'd1, 4'd9);
        send_request(SHAPE_EDGE, 2'd1, 2'd0, 4'd9);
        send_request(SHAPE_TRI,  2'd1, 2'd2, 4'd8);
        send_request(SHAPE_QUAD, 2'd3, 2'd0, 4'd7);
        send_request(SHAPE_TRI,  2'd0, 2'd0, 4'd1);
        wait_drain();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_shape         <= SHAPE_EDGE;
        i_first_corner  <= '0;
        i_second_corner <= '0;
        i_order         <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_low_order();
        test_bad_corner();
        test_edges();
        test_faces();
        wait_drain();
        test_backpressure();
        test_random(35, 81, 40);
        test_random(81, 35, 40);
        test_random(0, 0, 40);
        wait_drain();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && expected_dofs.size() == 0) begin
            $display("PASS dof_orientation_index_generator_unit");
        end else begin
            $display("FAIL dof_orientation_index_generator_unit");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL dof_orientation_index_generator_unit");
        $finish;
    end

endmodule
